[hdl/rpc_pkg.sv]
package rpc_pkg;

	localparam int DIR_FRAC = 14;
	localparam int CW = 28;
	localparam int PW = 58;
	localparam int RW = 58;
	localparam int QW = 26;
	localparam int IDX_W = 3;
	localparam int DATA_W = 23;

	localparam logic signed [CW-1:0] OUT_MAX = CW'(8388607);
	localparam logic signed [CW-1:0] OUT_MIN = CW'(-8388608);

	typedef enum logic [IDX_W-1:0] {
		REG_REACH      = 3'd0,
		REG_MARGIN_X   = 3'd1,
		REG_MARGIN_Y   = 3'd2,
		REG_AREA_RIGHT = 3'd3,
		REG_AREA_TOP   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLIP_BOTTOM,
		CLIP_LEFT,
		CLIP_RIGHT,
		CLIP_TOP
	} clip_edge_t;

	typedef struct packed {
		logic               anchor_stuck;
		logic signed [23:0] origin_x;
		logic signed [23:0] origin_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} item_t;

	typedef struct packed {
		logic               visible;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic               clipped;
	} result_t;

	typedef struct packed {
		logic [22:0] reach_length;
		logic [19:0] margin_x;
		logic [19:0] margin_y;
		logic [22:0] area_right;
		logic [22:0] area_top;
	} cfg_t;

	typedef struct packed {
		logic                 visible;
		logic                 clipped;
		logic                 divide;
		logic                 horiz;
		logic                 neg;
		logic                 ovf;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
	} side_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RW-1:0] dsh;
		logic [QW-1:0] quo;
		side_t         side;
	} div_t;

	function automatic logic in_open(input logic signed [PW-1:0] n,
		input logic signed [PW-1:0] d);
		return (d > 0) ? (n > 0 && n < d) : (n < 0 && n > d);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] c;
		c = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
		return c[23:0];
	endfunction

	function automatic logic signed [CW-1:0] scale_dir(input logic signed [39:0] p);
		logic [39:0] mag;
		logic [39:0] q;
		mag = p[39] ? 40'(-p) : 40'(p);
		q = (mag + (40'(1) << (DIR_FRAC - 1))) >> DIR_FRAC;
		return p[39] ? -$signed(CW'(q)) : $signed(CW'(q));
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return PW'(p);
	endfunction

endpackage

[hdl/rpc_div_cell.sv]
module rpc_div_cell import rpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  div_t up,
	output logic dn_valid,
	input  logic dn_ready,
	output div_t dn
);

	logic v_q;
	div_t d_q;
	div_t nxt;
	logic ge;

	assign up_ready = !v_q || dn_ready;

	always_comb begin
		ge = up.rem >= up.dsh;
		nxt = up;
		nxt.rem = ge ? up.rem - up.dsh : up.rem;
		nxt.dsh = up.dsh >> 1;
		nxt.quo = {up.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn = d_q;

endmodule

[hdl/rpc_front.sv]
module rpc_front import rpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  dn_valid,
	input  logic  dn_ready,
	output div_t  dn
);

	logic signed [CW-1:0] minx, maxx, miny, maxy, ax, ay;

	assign minx = $signed(CW'(cfg.margin_x));
	assign miny = $signed(CW'(cfg.margin_y));
	assign maxx = $signed(CW'(cfg.area_right)) - minx;
	assign maxy = $signed(CW'(cfg.area_top)) - miny;
	assign ax = maxx - minx;
	assign ay = maxy - miny;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic take_s1, take_s2, take_s3, take_s4, take_s5;

	assign take_s5 = !v_s5 || dn_ready;
	assign take_s4 = !v_s4 || take_s5;
	assign take_s3 = !v_s3 || take_s4;
	assign take_s2 = !v_s2 || take_s3;
	assign take_s1 = !v_s1 || take_s2;
	assign item_stall = !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (take_s1) v_s1 <= item_valid;
			if (take_s2) v_s2 <= v_s1;
			if (take_s3) v_s3 <= v_s2;
			if (take_s4) v_s4 <= v_s3;
			if (take_s5) v_s5 <= v_s4;
		end
	end

	// s1: scale direction by reach
	logic                 stuck_s1;
	logic signed [23:0]   ox_s1, oy_s1;
	logic signed [39:0]   pdx_s1, pdy_s1;
	logic signed [39:0]   dxe, dye, rch;

	assign dxe = {{24{item.dir_x[15]}}, item.dir_x};
	assign dye = {{24{item.dir_y[15]}}, item.dir_y};
	assign rch = {17'b0, cfg.reach_length};

	always_ff @(posedge clk) begin
		if (take_s1 && item_valid) begin
			stuck_s1 <= item.anchor_stuck;
			ox_s1    <= item.origin_x;
			oy_s1    <= item.origin_y;
			pdx_s1   <= dxe * rch;
			pdy_s1   <= dye * rch;
		end
	end

	// s2: target point and box test
	logic                 stuck_s2, inbox_s2;
	logic signed [CW-1:0] ox_s2, oy_s2, bx_s2, by_s2, tx_s2, ty_s2;
	logic signed [CW-1:0] oxe, oye, bxn, byn, txn, tyn;

	assign oxe = CW'(ox_s1);
	assign oye = CW'(oy_s1);
	assign bxn = scale_dir(pdx_s1);
	assign byn = scale_dir(pdy_s1);
	assign txn = oxe + bxn;
	assign tyn = oye + byn;

	always_ff @(posedge clk) begin
		if (take_s2 && v_s1) begin
			stuck_s2 <= stuck_s1;
			ox_s2    <= oxe;
			oy_s2    <= oye;
			bx_s2    <= bxn;
			by_s2    <= byn;
			tx_s2    <= txn;
			ty_s2    <= tyn;
			inbox_s2 <= (txn >= minx) && (txn <= maxx) && (tyn >= miny) && (tyn <= maxy);
		end
	end

	// s3: cross products and origin-side tests
	logic                 stuck_s3, inbox_s3;
	logic signed [CW-1:0] ox_s3, oy_s3, tx_s3, ty_s3;
	logic signed [PW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3, f_s3;
	logic                 hb_s3, hl_s3, hr_s3, ht_s3, ph_s3, pv_s3;

	always_ff @(posedge clk) begin
		if (take_s3 && v_s2) begin
			stuck_s3 <= stuck_s2;
			inbox_s3 <= inbox_s2;
			ox_s3    <= ox_s2;
			oy_s3    <= oy_s2;
			tx_s3    <= tx_s2;
			ty_s3    <= ty_s2;
			a_s3     <= mul(ox_s2 - minx, by_s2);
			b_s3     <= mul(ox_s2 - maxx, by_s2);
			c_s3     <= mul(oy_s2 - miny, bx_s2);
			d_s3     <= mul(oy_s2 - maxy, bx_s2);
			e_s3     <= mul(ax, by_s2);
			f_s3     <= mul(ay, bx_s2);
			hb_s3    <= in_open(PW'(miny - oy_s2), PW'(by_s2));
			hl_s3    <= in_open(PW'(minx - ox_s2), PW'(bx_s2));
			hr_s3    <= in_open(PW'(maxx - ox_s2), PW'(bx_s2));
			ht_s3    <= in_open(PW'(maxy - oy_s2), PW'(by_s2));
			ph_s3    <= (ax == '0) || (by_s2 == '0);
			pv_s3    <= (ay == '0) || (bx_s2 == '0);
		end
	end

	// s4: first crossed edge
	logic signed [PW-1:0] n2b, n2r, n2t, nf;
	logic                 hit_b, hit_l, hit_r, hit_t;
	clip_edge_t           sel;
	side_t                side_n, side_s4;
	logic signed [PW-1:0] num_n, num_s4;
	logic signed [CW-1:0] den_n, den_s4;
	logic                 par;
	logic signed [CW-1:0] fix;

	assign n2b = a_s3 - c_s3;
	assign n2r = b_s3 - c_s3;
	assign n2t = a_s3 - d_s3;
	assign nf  = -f_s3;
	assign hit_b = !ph_s3 && hb_s3 && in_open(n2b, e_s3);
	assign hit_l = !pv_s3 && hl_s3 && in_open(n2b, nf);
	assign hit_r = !pv_s3 && hr_s3 && in_open(n2r, nf);
	assign hit_t = !ph_s3 && ht_s3 && in_open(n2t, e_s3);

	always_comb begin
		sel = hit_b ? CLIP_BOTTOM : (hit_l ? CLIP_LEFT : (hit_r ? CLIP_RIGHT : CLIP_TOP));
		side_n = '0;
		num_n = -c_s3;
		par = ph_s3;
		fix = miny;
		case (sel)
			CLIP_BOTTOM: begin
				side_n.horiz = 1'b1; par = ph_s3; fix = miny; num_n = -c_s3;
			end
			CLIP_LEFT: begin
				side_n.horiz = 1'b0; par = pv_s3; fix = minx; num_n = -a_s3;
			end
			CLIP_RIGHT: begin
				side_n.horiz = 1'b0; par = pv_s3; fix = maxx; num_n = -b_s3;
			end
			CLIP_TOP: begin
				side_n.horiz = 1'b1; par = ph_s3; fix = maxy; num_n = -d_s3;
			end
			default: begin
				side_n.horiz = 1'b1; par = ph_s3; fix = maxy; num_n = -d_s3;
			end
		endcase
		den_n = side_n.horiz ? (ty_s3 - oy_s3) : (tx_s3 - ox_s3);
		if (stuck_s3) begin
			side_n = '0;
		end else if (inbox_s3) begin
			side_n.visible = 1'b1;
			side_n.px = tx_s3;
			side_n.py = ty_s3;
		end else begin
			side_n.visible = 1'b1;
			side_n.clipped = 1'b1;
			side_n.divide = !par;
			if (side_n.horiz) begin
				side_n.px = par ? minx : ox_s3;
				side_n.py = fix;
			end else begin
				side_n.px = fix;
				side_n.py = par ? miny : oy_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s4 && v_s3) begin
			side_s4 <= side_n;
			num_s4  <= num_n;
			den_s4  <= den_n;
		end
	end

	// s5: divider setup
	logic [PW-1:0] un;
	logic [CW-1:0] ud;
	logic [RW-1:0] nn, dd;
	div_t          job_n, job_s5;

	always_comb begin
		un = num_s4[PW-1] ? PW'(-num_s4) : PW'(num_s4);
		ud = den_s4[CW-1] ? CW'(-den_s4) : CW'(den_s4);
		nn = (RW'(un) << 1) + RW'(ud);
		dd = RW'(ud) << 1;
		job_n.rem = nn;
		job_n.dsh = dd << (QW - 1);
		job_n.quo = '0;
		job_n.side = side_s4;
		job_n.side.neg = num_s4[PW-1] ^ den_s4[CW-1];
		job_n.side.ovf = nn >= (dd << QW);
	end

	always_ff @(posedge clk) begin
		if (take_s5 && v_s4) begin
			job_s5 <= job_n;
		end
	end

	assign dn_valid = v_s5;
	assign dn = job_s5;

endmodule

[hdl/ray_point_clip_to_rectangle_unit.sv]
// Ray point clipped to a rectangle.
// Item channel: item_valid / item_stall carry origin, unit direction and the
// stuck flag. Result channel: result_valid / result_stall carry the marker
// point, visible and clipped flags. One result per item, in order.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write reach,
// margins and area edges; cfg_ready is always high. Write only while idle.
// Pipeline: five front stages (scale, box test, cross products, edge pick,
// divider setup), a chain of 26 restoring divider cells, one per quotient
// bit, and the output register lie between item transfer and result_valid.
// Throughput: one item per cycle while result_stall is low; every stage and
// cell accepts new data in the cycle its content moves on, so bubbles are
// squeezed out. Reset: empties the pipeline and loads reach 51200 and zero
// box registers. When the receiver stalls, the result holds; the pipeline
// keeps filling and item_stall rises only once every stage holds an item.
module ray_point_clip_to_rectangle_unit import rpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{reach_length: 23'd51200, default: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REACH:      cfg_q.reach_length <= cfg_data;
				REG_MARGIN_X:   cfg_q.margin_x <= cfg_data[19:0];
				REG_MARGIN_Y:   cfg_q.margin_y <= cfg_data[19:0];
				REG_AREA_RIGHT: cfg_q.area_right <= cfg_data;
				REG_AREA_TOP:   cfg_q.area_top <= cfg_data;
				default: ;
			endcase
		end
	end

	logic       cv [QW+1];
	logic       cr [QW+1];
	div_t       cd [QW+1];

	rpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.dn_valid   (cv[0]),
		.dn_ready   (cr[0]),
		.dn         (cd[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_cell
		rpc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cv[i]),
			.up_ready (cr[i]),
			.up       (cd[i]),
			.dn_valid (cv[i+1]),
			.dn_ready (cr[i+1]),
			.dn       (cd[i+1])
		);
	end

	logic                 out_v_q;
	result_t              out_q;
	div_t                 fin;
	logic signed [CW-1:0] mag, base, val, x, y;
	result_t              res_n;

	assign fin = cd[QW];
	assign cr[QW] = !out_v_q || !result_stall;

	always_comb begin
		mag  = $signed(CW'(fin.quo));
		base = fin.side.horiz ? fin.side.px : fin.side.py;
		if (fin.side.ovf) begin
			val = fin.side.neg ? OUT_MIN : OUT_MAX;
		end else begin
			val = fin.side.neg ? base - mag : base + mag;
		end
		x = fin.side.px;
		y = fin.side.py;
		if (fin.side.divide) begin
			if (fin.side.horiz) begin
				x = val;
			end else begin
				y = val;
			end
		end
		res_n.visible = fin.side.visible;
		res_n.clipped = fin.side.clipped;
		res_n.point_x = sat24(x);
		res_n.point_y = sat24(y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cr[QW]) begin
			out_v_q <= cv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (cr[QW] && cv[QW]) begin
			out_q <= res_n;
		end
	end

	assign result_valid = out_v_q;
	assign result = out_q;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.visible |->
			result.point_x == '0 && result.point_y == '0 && !result.clipped)
		else $error("hidden result carries a position");

	a_clip_visible: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clipped |-> result.visible)
		else $error("clipped result not visible");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stalled while output can drain");

endmodule
